FILE: design/utc_pkg.sv
package utc_pkg;

    localparam int LEAP_TABLE_SIZE = 17;
    localparam int LEAP_ENTRIES_DEF = 17;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [25:0] second_us;
    } utc_in_t;

    typedef struct packed {
        logic [51:0] gps_time_us;
        logic [12:0] week_number;
        logic [4:0]  leap_seconds;
    } utc_out_t;

    // Days before each month in a common year, index = months passed
    function automatic logic [8:0] days_before(input logic [3:0] passed);
        logic [8:0] r;
        begin
            case (passed)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd59;
                4'd3:    r = 9'd90;
                4'd4:    r = 9'd120;
                4'd5:    r = 9'd151;
                4'd6:    r = 9'd181;
                4'd7:    r = 9'd212;
                4'd8:    r = 9'd243;
                4'd9:    r = 9'd273;
                4'd10:   r = 9'd304;
                4'd11:   r = 9'd334;
                default: r = 9'd365;
            endcase
            return r;
        end
    endfunction

    // Leap step date key (year<<9 | month<<5 | day), newest first
    function automatic logic [20:0] leap_key(input logic [4:0] idx);
        logic [20:0] r;
        begin
            case (idx)
                5'd0:    r = {12'd2015, 4'd7, 5'd1};
                5'd1:    r = {12'd2012, 4'd7, 5'd1};
                5'd2:    r = {12'd2009, 4'd1, 5'd1};
                5'd3:    r = {12'd2006, 4'd1, 5'd1};
                5'd4:    r = {12'd1999, 4'd1, 5'd1};
                5'd5:    r = {12'd1997, 4'd7, 5'd1};
                5'd6:    r = {12'd1996, 4'd1, 5'd1};
                5'd7:    r = {12'd1994, 4'd7, 5'd1};
                5'd8:    r = {12'd1993, 4'd7, 5'd1};
                5'd9:    r = {12'd1992, 4'd7, 5'd1};
                5'd10:   r = {12'd1991, 4'd1, 5'd1};
                5'd11:   r = {12'd1990, 4'd1, 5'd1};
                5'd12:   r = {12'd1988, 4'd1, 5'd1};
                5'd13:   r = {12'd1985, 4'd7, 5'd1};
                5'd14:   r = {12'd1983, 4'd7, 5'd1};
                5'd15:   r = {12'd1982, 4'd7, 5'd1};
                5'd16:   r = {12'd1981, 4'd7, 5'd1};
                default: r = '1;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] leap_val(input logic [4:0] idx);
        return (idx < 5'(LEAP_TABLE_SIZE)) ? 5'(LEAP_TABLE_SIZE - 32'(idx)) : 5'd0;
    endfunction

endpackage

FILE: design/utc_day_count.sv
// Day count since the 1981 origin: year offset in closed form, then day of year.
module utc_day_count (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  utc_pkg::utc_in_t      din,
    output logic [19:0]           ttl
);
    import utc_pkg::*;

    logic [11:0] dy;
    logic [19:0] base_next, base_reg;
    logic [8:0]  doy_next, doy_reg;
    logic [3:0]  passed;
    logic        leap_yr;
    logic [9:0]  n4;
    logic [4:0]  n100;
    logic [2:0]  n400;
    logic [11:0] ym1, yl;
    logic [24:0] prod_ym1, prod_yr;
    logic [11:0] q_ym1, q_yr, rem_yr;

    // Stage A: whole years before this one, with leap days, and day of year
    always_comb
    begin
        yl   = (din.year > 12'd1981) ? din.year : 12'd1981;
        dy   = yl - 12'd1981;
        ym1  = yl - 12'd1;
        // Divide by 100 by reciprocal, exact for 12-bit years
        prod_ym1 = 25'(ym1) * 25'd5243;
        q_ym1    = 12'(prod_ym1 >> 19);
        prod_yr  = 25'(din.year) * 25'd5243;
        q_yr     = 12'(prod_yr >> 19);
        rem_yr   = din.year - q_yr * 12'd100;
        // leap years in [1981, year-1] = f(year-1) - f(1980)
        n4   = 10'((ym1 >> 2) - 12'd495);
        n100 = 5'(q_ym1 - 12'd19);
        n400 = 3'((q_ym1 >> 2) - 12'd4);
        base_next = 20'd360 + 20'(dy) * 20'd365 + 20'(n4) - 20'(n100) + 20'(n400);
        passed = (din.month == 4'd0) ? 4'd0 : din.month - 4'd1;
        if (passed > 4'd12)
        begin
            passed = 4'd12;
        end
        leap_yr = ((din.year[1:0] == 2'd0) && (rem_yr != 12'd0))
                  || ((rem_yr == 12'd0) && (q_yr[1:0] == 2'd0));
        doy_next = days_before(passed) + 9'(din.day)
                   + 9'((passed >= 4'd2) && leap_yr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            doy_reg  <= '0;
        end
        else if (advance)
        begin
            base_reg <= base_next;
            doy_reg  <= doy_next;
        end
    end

    assign ttl = base_reg + 20'(doy_reg);

endmodule

FILE: design/utc_to_gps_time_converter.sv
// UTC to GPS time converter.
// Input channel: valid/ready carrying one utc_in_t request (date and time).
// Output channel: valid/ready carrying one utc_out_t result per request.
// Pipeline of four register stages: day count and day of year, total day and
// leap lookup, week split and seconds, microsecond scaling. An item enters
// every cycle while in_ready is high.
// Seconds are formed as total days times 86400, so the week split only feeds
// the week number. The leap offset is a parallel compare against the step table.
// When the receiver stalls, full stages hold and in_ready drops only when all
// four stages are full and the output is not taken; nothing is lost or repeated.
// Reset clears all valid bits; the block is empty and ready after reset.
module utc_to_gps_time_converter #(
    parameter int LEAP_ENTRIES = utc_pkg::LEAP_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  utc_pkg::utc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output utc_pkg::utc_out_t out_data
);
    import utc_pkg::*;

    logic [3:0] v_reg;
    logic [3:0] adv;
    logic [19:0] ttl;

    utc_in_t     s1_reg;
    logic [4:0]  leap_s2_next, leap_s2_reg, leap_s3_reg;
    logic [19:0] ttl_reg;
    utc_in_t     s2_reg;
    logic [12:0] week_reg;
    logic [36:0] secs_next, secs_reg;
    logic [25:0] sus_reg;
    logic [51:0] us_next, us_reg;
    logic [12:0] week_out_reg;
    logic [4:0]  leap_out_reg;
    logic [12:0] wk;
    logic [40:0] wk_prod;
    logic [20:0] key;

    // Stall chain: a stage moves when the one after it frees up
    assign adv[3] = !v_reg[3] || out_ready;
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    utc_day_count u_days (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (adv[0]),
        .din     (in_data),
        .ttl     (ttl)
    );

    // Leap lookup: first step not after the date, newest first
    always_comb
    begin
        key = {s1_reg.year, s1_reg.month, s1_reg.day};
        leap_s2_next = 5'd0;
        for (int i = LEAP_TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (i < LEAP_ENTRIES && leap_key(5'(i)) <= key)
            begin
                leap_s2_next = leap_val(5'(i));
            end
        end
    end

    // Week split by reciprocal: ttl/7, exact for ttl < 2^20, kept to 13 bits; also total seconds with leap offset
    always_comb
    begin
        wk_prod = 41'(ttl_reg) * 41'd1198373;
        wk = 13'(wk_prod >> 23);
        secs_next = 37'(ttl_reg) * 37'd86400 + 37'(s2_reg.hour) * 37'd3600
                    + 37'(s2_reg.minute) * 37'd60 + 37'(leap_s2_reg);
    end

    // Scale to microseconds: 10^6 = 15625 << 6
    assign us_next = 52'((64'(secs_reg) * 64'd15625) << 6) + 52'(sus_reg);

    always_ff @(posedge clk)
    begin
        if (adv[0]) s1_reg <= in_data;
        if (adv[1])
        begin
            s2_reg      <= s1_reg;
            ttl_reg     <= ttl;
            leap_s2_reg <= leap_s2_next;
        end
        if (adv[2])
        begin
            secs_reg    <= secs_next;
            sus_reg     <= s2_reg.second_us;
            week_reg    <= wk;
            leap_s3_reg <= leap_s2_reg;
        end
        if (adv[3])
        begin
            us_reg       <= us_next;
            week_out_reg <= week_reg;
            leap_out_reg <= leap_s3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = '{gps_time_us: us_reg, week_number: week_out_reg,
                         leap_seconds: leap_out_reg};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_leap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.leap_seconds <= 5'(LEAP_TABLE_SIZE))
        else $error("leap offset out of table");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

endmodule
